>>> design/frwl_pkg.sv
package frwl_pkg;

    // Field widths fixed by the interface.
    localparam int TAG_W     = 8;
    localparam int GEN_W     = 32;
    localparam int READERS_W = 16;

    // Default waiter queue depth and the reader count ceiling.
    localparam int DEFAULT_WAIT_DEPTH = 16;
    localparam logic [READERS_W-1:0] READER_MAX = {READERS_W{1'b1}};

    // Depth of the command queue between the front and back parts (power of two).
    localparam int CMDQ_DEPTH = 2;

    // Operation and mode codes.
    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_GRANTED  = 3'd0,
        ST_STALE    = 3'd1,
        ST_QUEUED   = 3'd2,
        ST_FULL     = 3'd3,
        ST_RELEASED = 3'd4,
        ST_NOT_HELD = 3'd5
    } status_t;

    // Classified command handed from the front part to the back part.
    // For an acquire, gen is the requested generation; for a release it is the
    // current generation that waiters are checked against.
    typedef struct packed {
        logic             op;
        logic             mode;
        logic [TAG_W-1:0] tag;
        logic [GEN_W-1:0] gen;
        logic             stale;
    } cmd_t;

    // One waiter queue entry.
    typedef struct packed {
        logic [GEN_W-1:0] gen;
        logic             mode;
        logic [TAG_W-1:0] tag;
    } waiter_t;

    // One buffered result, before the final lock state is attached.
    typedef struct packed {
        logic [TAG_W-1:0] tag;
        status_t          status;
        logic             mode;
    } res_t;

    // Address width for a store of the given depth (at least one bit).
    function automatic int frwl_aw(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

>>> design/frwl_ram.sv
module frwl_ram
    import frwl_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = frwl_aw(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> design/frwl_front.sv
module frwl_front
    import frwl_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_operation,
    input  logic             s_lock_mode,
    input  logic [TAG_W-1:0] s_requester_tag,
    input  logic [GEN_W-1:0] s_requested_generation,
    input  logic [GEN_W-1:0] s_current_generation,
    output logic             q_valid,
    input  logic             q_ready,
    output cmd_t             q_cmd
);

    logic fr_valid_reg;
    logic fr_valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    // The stage takes a new transfer when empty or when its command moves on.
    assign s_ready = !fr_valid_reg || q_ready;

    // Classify the item: flag stale acquires and pick the generation to carry.
    always_comb begin
        fr_valid_next = fr_valid_reg;
        cmd_next      = cmd_reg;
        if (s_ready) begin
            fr_valid_next = s_valid;
        end
        if (s_valid && s_ready) begin
            cmd_next.op    = s_operation;
            cmd_next.mode  = s_lock_mode;
            cmd_next.tag   = s_requester_tag;
            cmd_next.stale = (s_operation == OP_ACQUIRE) &&
                             (s_requested_generation != s_current_generation);
            cmd_next.gen   = (s_operation == OP_ACQUIRE) ? s_requested_generation
                                                         : s_current_generation;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fr_valid_reg <= 1'b0;
        end else begin
            fr_valid_reg <= fr_valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign q_valid = fr_valid_reg;
    assign q_cmd   = cmd_reg;

endmodule

>>> design/frwl_cmd_fifo.sv
module frwl_cmd_fifo
    import frwl_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PW = frwl_aw(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    cmd_t          entry_reg [CMDQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != CW'(CMDQ_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and occupancy update.
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

>>> design/frwl_back.sv
module frwl_back
    import frwl_pkg::*;
#(
    parameter int WAIT_DEPTH = DEFAULT_WAIT_DEPTH,
    localparam int CW = $clog2(WAIT_DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [TAG_W-1:0]     m_result_tag,
    output logic [2:0]           m_status,
    output logic                 m_result_mode,
    output logic [READERS_W-1:0] m_readers_now,
    output logic                 m_writer_now,
    output logic [CW-1:0]        m_waiting_now,
    output logic                 m_last
);

    localparam int QW     = frwl_aw(WAIT_DEPTH);
    localparam int RDEPTH = WAIT_DEPTH + 1;
    localparam int RAW    = frwl_aw(RDEPTH);
    localparam int NW     = $clog2(WAIT_DEPTH + 2);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_FINAL,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t                state_reg, state_next;
    cmd_t                  cmd_reg, cmd_next;
    logic                  writer_reg, writer_next;
    logic [READERS_W-1:0]  readers_reg, readers_next;
    logic [QW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [NW-1:0]         nres_reg, nres_next;
    logic [NW-1:0]         ridx_reg, ridx_next;
    logic                  m_valid_reg, m_valid_next;
    logic [TAG_W-1:0]      m_tag_reg, m_tag_next;
    logic [2:0]            m_status_reg, m_status_next;
    logic                  m_mode_reg, m_mode_next;
    logic [READERS_W-1:0]  m_readers_reg, m_readers_next;
    logic                  m_writer_reg, m_writer_next;
    logic [CW-1:0]         m_waiting_reg, m_waiting_next;
    logic                  m_last_reg, m_last_next;

    // Waiter store and result buffer ports.
    logic                  w_we;
    logic [QW-1:0]         w_waddr;
    waiter_t               w_wdata;
    logic                  w_re;
    waiter_t               w_rdata;
    logic                  r_we;
    logic [RAW-1:0]        r_waddr;
    res_t                  r_wdata;
    logic                  r_re;
    res_t                  r_rdata;

    logic [CW:0]           slot_sum;
    logic [QW-1:0]         slot;
    logic [QW-1:0]         head_inc;
    logic                  held;
    logic                  pop;
    logic                  go_on;
    logic                  emit_last;

    frwl_ram #(
        .WIDTH ($bits(waiter_t)),
        .DEPTH (WAIT_DEPTH)
    ) u_waiter_ram (
        .aclk  (aclk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .re    (w_re),
        .raddr (head_next),
        .rdata (w_rdata)
    );

    frwl_ram #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RDEPTH)
    ) u_result_ram (
        .aclk  (aclk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .re    (r_re),
        .raddr (ridx_reg[RAW-1:0]),
        .rdata (r_rdata)
    );

    // A mode can be taken when no writer holds the lock and, for a write,
    // no readers do; a read also needs room in the reader count.
    function automatic logic can_take(input logic mode, input logic writer,
                                      input logic [READERS_W-1:0] readers);
        logic ok;
        if (mode == MODE_WRITE) begin
            ok = !writer && (readers == '0);
        end else begin
            ok = !writer && (readers != READER_MAX);
        end
        return ok;
    endfunction

    // Tail slot of the waiter ring and the next head position.
    always_comb begin
        slot_sum = (CW+1)'(head_reg) + (CW+1)'(count_reg);
        if (slot_sum >= (CW+1)'(WAIT_DEPTH)) begin
            slot_sum = slot_sum - (CW+1)'(WAIT_DEPTH);
        end
        slot     = slot_sum[QW-1:0];
        head_inc = (head_reg == QW'(WAIT_DEPTH - 1)) ? '0 : head_reg + QW'(1);
    end

    assign cmd_ready = (state_reg == S_IDLE);
    assign held      = (cmd_reg.mode == MODE_WRITE) ? writer_reg : (readers_reg != '0);
    assign emit_last = ((ridx_reg + NW'(1)) == nres_reg);

    // Sequencer: execute one command, walk the waiters after a held release, then drain results.
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        writer_next    = writer_reg;
        readers_next   = readers_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        nres_next      = nres_reg;
        ridx_next      = ridx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_tag_next     = m_tag_reg;
        m_status_next  = m_status_reg;
        m_mode_next    = m_mode_reg;
        m_readers_next = m_readers_reg;
        m_writer_next  = m_writer_reg;
        m_waiting_next = m_waiting_reg;
        m_last_next    = m_last_reg;
        w_we           = 1'b0;
        w_waddr        = slot;
        w_wdata        = '{gen: cmd_reg.gen, mode: cmd_reg.mode, tag: cmd_reg.tag};
        w_re           = 1'b0;
        r_we           = 1'b0;
        r_waddr        = nres_reg[RAW-1:0];
        r_wdata        = '{tag: cmd_reg.tag, status: ST_RELEASED, mode: cmd_reg.mode};
        r_re           = 1'b0;
        pop            = 1'b0;
        go_on          = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                if (cmd_valid) begin
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end

            S_EXEC: begin
                ridx_next = '0;
                if (cmd_reg.op == OP_ACQUIRE) begin
                    // Every acquire gives exactly one result.
                    r_we       = 1'b1;
                    r_waddr    = '0;
                    nres_next  = NW'(1);
                    state_next = S_DRAIN;
                    priority if (cmd_reg.stale) begin
                        r_wdata.status = ST_STALE;
                    end else if (can_take(cmd_reg.mode, writer_reg, readers_reg)) begin
                        r_wdata.status = ST_GRANTED;
                        if (cmd_reg.mode == MODE_WRITE) begin
                            writer_next = 1'b1;
                        end else begin
                            readers_next = readers_reg + READERS_W'(1);
                        end
                    end else if ((cmd_reg.mode == MODE_READ && !writer_reg) ||
                                 (count_reg >= CW'(WAIT_DEPTH))) begin
                        r_wdata.status = ST_FULL;
                    end else begin
                        r_wdata.status = ST_QUEUED;
                        w_we           = 1'b1;
                        count_next     = count_reg + CW'(1);
                    end
                end else if (!held) begin
                    r_we           = 1'b1;
                    r_waddr        = '0;
                    r_wdata.status = ST_NOT_HELD;
                    nres_next      = NW'(1);
                    state_next     = S_DRAIN;
                end else begin
                    // Drop the held mode, then look at the oldest waiter.
                    if (cmd_reg.mode == MODE_WRITE) begin
                        writer_next = 1'b0;
                    end else begin
                        readers_next = readers_reg - READERS_W'(1);
                    end
                    nres_next = '0;
                    if (count_reg != '0) begin
                        w_re       = 1'b1;
                        state_next = S_WALK;
                    end else begin
                        state_next = S_FINAL;
                    end
                end
            end

            S_WALK: begin
                // The head waiter's entry is in the read register.
                r_wdata.tag  = w_rdata.tag;
                r_wdata.mode = w_rdata.mode;
                if (w_rdata.gen != cmd_reg.gen) begin
                    pop            = 1'b1;
                    go_on          = 1'b1;
                    r_wdata.status = ST_STALE;
                end else if (can_take(w_rdata.mode, writer_reg, readers_reg)) begin
                    pop            = 1'b1;
                    go_on          = (w_rdata.mode == MODE_READ);
                    r_wdata.status = ST_GRANTED;
                    if (w_rdata.mode == MODE_WRITE) begin
                        writer_next = 1'b1;
                    end else begin
                        readers_next = readers_reg + READERS_W'(1);
                    end
                end
                if (pop) begin
                    r_we       = 1'b1;
                    nres_next  = nres_reg + NW'(1);
                    head_next  = head_inc;
                    count_next = count_reg - CW'(1);
                end
                if (go_on && (count_next != '0)) begin
                    w_re       = 1'b1;
                    state_next = S_WALK;
                end else begin
                    state_next = S_FINAL;
                end
            end

            S_FINAL: begin
                r_we       = 1'b1;
                nres_next  = nres_reg + NW'(1);
                state_next = S_DRAIN;
            end

            S_DRAIN: begin
                r_re       = 1'b1;
                state_next = S_EMIT;
            end

            S_EMIT: begin
                // Attach the lock state left by the whole step to each result.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_tag_next     = r_rdata.tag;
                    m_status_next  = r_rdata.status;
                    m_mode_next    = r_rdata.mode;
                    m_readers_next = readers_reg;
                    m_writer_next  = writer_reg;
                    m_waiting_next = count_reg;
                    m_last_next    = emit_last;
                    ridx_next      = ridx_reg + NW'(1);
                    state_next     = emit_last ? S_IDLE : S_DRAIN;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            writer_reg  <= 1'b0;
            readers_reg <= '0;
            head_reg    <= '0;
            count_reg   <= '0;
            nres_reg    <= '0;
            ridx_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            writer_reg  <= writer_next;
            readers_reg <= readers_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            nres_reg    <= nres_next;
            ridx_reg    <= ridx_next;
            m_valid_reg <= m_valid_next;
        end
        cmd_reg       <= cmd_next;
        m_tag_reg     <= m_tag_next;
        m_status_reg  <= m_status_next;
        m_mode_reg    <= m_mode_next;
        m_readers_reg <= m_readers_next;
        m_writer_reg  <= m_writer_next;
        m_waiting_reg <= m_waiting_next;
        m_last_reg    <= m_last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_result_tag  = m_tag_reg;
    assign m_status      = m_status_reg;
    assign m_result_mode = m_mode_reg;
    assign m_readers_now = m_readers_reg;
    assign m_writer_now  = m_writer_reg;
    assign m_waiting_now = m_waiting_reg;
    assign m_last        = m_last_reg;

endmodule

>>> design/fifo_reader_writer_lock_core.sv
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    operation, lock_mode, requester_tag,
//                                         requested_generation, current_generation
// m_        out        m_valid/m_ready    result_tag, status, result_mode, readers_now,
//                                         writer_now, waiting_now, last
//
// An acquire, or a release of a mode that is not held, is executed and then drained in
// the back part. A held release reads each waiter that it pops from the waiter RAM, and
// one more when the walk stops at a waiter that cannot be served; then each result is
// drained from the result buffer, whose registered read port puts a drain state before
// each emit state.
// Reset (aresetn, synchronous, active low) empties the lock and the waiter queue.
// The front stage and a two-entry command queue keep taking transfers, until they fill,
// while the back part works or the output register waits on m_ready.
module fifo_reader_writer_lock_core
    import frwl_pkg::*;
#(
    parameter int WAIT_DEPTH = DEFAULT_WAIT_DEPTH,
    localparam int CW = $clog2(WAIT_DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_operation,
    input  logic                 s_lock_mode,
    input  logic [TAG_W-1:0]     s_requester_tag,
    input  logic [GEN_W-1:0]     s_requested_generation,
    input  logic [GEN_W-1:0]     s_current_generation,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [TAG_W-1:0]     m_result_tag,
    output logic [2:0]           m_status,
    output logic                 m_result_mode,
    output logic [READERS_W-1:0] m_readers_now,
    output logic                 m_writer_now,
    output logic [CW-1:0]        m_waiting_now,
    output logic                 m_last
);

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic qb_valid;
    logic qb_ready;
    cmd_t qb_cmd;

    // Front part: input stage and classification.
    frwl_front u_front (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_operation            (s_operation),
        .s_lock_mode            (s_lock_mode),
        .s_requester_tag        (s_requester_tag),
        .s_requested_generation (s_requested_generation),
        .s_current_generation   (s_current_generation),
        .q_valid                (fq_valid),
        .q_ready                (fq_ready),
        .q_cmd                  (fq_cmd)
    );

    // Command queue between the two parts.
    frwl_cmd_fifo u_cmd_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_cmd    (fq_cmd),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_cmd   (qb_cmd)
    );

    // Back part: lock state, waiter queue and result sequencing.
    frwl_back #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd_valid     (qb_valid),
        .cmd_ready     (qb_ready),
        .cmd           (qb_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_tag  (m_result_tag),
        .m_status      (m_status),
        .m_result_mode (m_result_mode),
        .m_readers_now (m_readers_now),
        .m_writer_now  (m_writer_now),
        .m_waiting_now (m_waiting_now),
        .m_last        (m_last)
    );

    // A writer never coexists with readers.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_writer_now |-> m_readers_now == '0)
        else $error("writer reported together with readers");

    // A queued request leaves at least one waiter behind.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_QUEUED |-> m_waiting_now != '0)
        else $error("queued result with an empty waiter queue");

    // Only grants and stale waiters can precede the final result of a step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_QUEUED || m_status == ST_FULL ||
                    m_status == ST_RELEASED || m_status == ST_NOT_HELD) |-> m_last)
        else $error("closing status without the last flag");

    // The waiter count never exceeds the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_waiting_now <= CW'(WAIT_DEPTH))
        else $error("waiter count beyond the queue depth");

endmodule
